/* src/apu_pkg.sv */
// Shared constants, types and the arctangent table of the pose update unit.
package apu_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int NSTEPS = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
   localparam int STEP_W = 5;
   localparam int XY_W = 48;
   localparam int Z_W = 34;
   localparam int DIV_W = 64;
   localparam int DIVISOR_W = 24;
   localparam int DIV_CNT_W = $clog2(DIV_W);

   localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);
   localparam logic signed [31:0] TURN_OVER_2PI_Q8 = 32'sd2670177;

   typedef enum logic [2:0] {
      CSR_WHEELBASE = 3'd0,
      CSR_STEER_IS_ANGLE = 3'd1,
      CSR_START_X = 3'd2,
      CSR_START_Y = 3'd3,
      CSR_START_HEADING = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic start;
      logic vectoring;
   } cor_ctl_type;

   function automatic logic [31:0] atan_entry(input logic [STEP_W-1:0] idx);
      logic [31:0] val;
      unique case (idx)
         5'd0:  val = 32'h20000000;
         5'd1:  val = 32'h12E4051D;
         5'd2:  val = 32'h09FB385B;
         5'd3:  val = 32'h051111D4;
         5'd4:  val = 32'h028B0D43;
         5'd5:  val = 32'h0145D7E1;
         5'd6:  val = 32'h00A2F61E;
         5'd7:  val = 32'h00517C55;
         5'd8:  val = 32'h0028BE53;
         5'd9:  val = 32'h00145F2E;
         5'd10: val = 32'h000A2F98;
         5'd11: val = 32'h000517CC;
         5'd12: val = 32'h00028BE6;
         5'd13: val = 32'h000145F3;
         5'd14: val = 32'h0000A2F9;
         5'd15: val = 32'h0000517C;
         5'd16: val = 32'h000028BE;
         5'd17: val = 32'h0000145F;
         5'd18: val = 32'h00000A2F;
         5'd19: val = 32'h00000517;
         5'd20: val = 32'h0000028B;
         5'd21: val = 32'h00000145;
         5'd22: val = 32'h000000A2;
         5'd23: val = 32'h00000051;
         default: val = 32'h0;
      endcase
      return val;
   endfunction

endpackage

/* src/apu_cordic.sv */
// Iterative CORDIC, one micro-rotation per cycle, rotation or vectoring mode.
module apu_cordic import apu_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  cor_ctl_type            ctl,
   input  logic signed [XY_W-1:0] x_init,
   input  logic signed [XY_W-1:0] y_init,
   input  logic signed [Z_W-1:0]  z_init,
   output logic signed [XY_W-1:0] x_out,
   output logic signed [XY_W-1:0] y_out,
   output logic signed [Z_W-1:0]  z_out,
   output logic                   done
);

   logic signed [XY_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [Z_W-1:0]  z_ff, z_in;
   logic [STEP_W-1:0]      cnt_ff, cnt_in;
   logic                   busy_ff, busy_in, vec_ff, vec_in, done_ff, done_in;
   logic signed [XY_W-1:0] xs, ys;
   logic signed [Z_W-1:0]  ang;
   logic                   ccw;

   always_comb begin
      xs  = x_ff >>> cnt_ff;
      ys  = y_ff >>> cnt_ff;
      ang = $signed({2'b00, atan_entry(cnt_ff)});
      // vectoring drives y toward zero, rotation drives z toward zero
      ccw = vec_ff ? y_ff[XY_W-1] : ~z_ff[Z_W-1];
      x_in = x_ff; y_in = y_ff; z_in = z_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; vec_in = vec_ff; done_in = 1'b0;
      if (ctl.start) begin
         x_in = x_init; y_in = y_init; z_in = z_init;
         cnt_in = '0; busy_in = 1'b1; vec_in = ctl.vectoring;
      end else if (busy_ff) begin
         if (ccw) begin
            x_in = x_ff - ys; y_in = y_ff + xs; z_in = z_ff - ang;
         end else begin
            x_in = x_ff + ys; y_in = y_ff - xs; z_in = z_ff + ang;
         end
         cnt_in = cnt_ff + STEP_W'(1);
         if (cnt_ff == STEP_W'(NSTEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in;
      cnt_ff <= cnt_in; vec_ff <= vec_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;
   assign done  = done_ff;

endmodule

/* src/apu_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module apu_div import apu_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_W-1:0]     dividend,
   input  logic [DIVISOR_W-1:0] divisor,
   output logic [DIV_W-1:0]     quotient,
   output logic                 done
);

   logic [DIV_W-1:0]     q_ff, q_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in, dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [DIVISOR_W:0]   rem_sh;
   logic                 fits;

   always_comb begin
      rem_sh = {rem_ff, q_ff[DIV_W-1]};
      fits   = rem_sh >= {1'b0, dvs_ff};
      q_in = q_ff; rem_in = rem_ff; dvs_in = dvs_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         q_in = dividend; rem_in = '0; dvs_in = divisor; cnt_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? DIVISOR_W'(rem_sh - {1'b0, dvs_ff}) : rem_sh[DIVISOR_W-1:0];
         q_in   = {q_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; rem_ff <= rem_in; dvs_ff <= dvs_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = q_ff;
   assign done     = done_ff;

endmodule

/* src/ackermann_pose_update_unit.sv */
// Top level of the kinematic bicycle pose update unit.
// Usage:
//  - req_ beat: cmd (0 advance, 1 restart), speed, steer_or_rate, time_step.
//    Accepted when req_valid is high and req_stall is low.
//  - rsp_ beat: the new pose (pos_x, pos_y, heading), one per request.
//  - csr_ port: write-only, csr_index selects wheelbase, steer_is_angle,
//    start_x, start_y, start_heading; write only while the block is idle.
//  - One item at a time: req_stall is high from acceptance until the result
//    is moved into the output register.
//  - Advance sequence, acceptance to rsp_valid, in yaw-rate mode: three CORDIC
//    passes, each with a load step, eight multiply steps on the shared
//    multiplier, the bit-serial divider, one heading and one output step;
//    angle mode skips the product and arctangent pass. A restart goes
//    straight to the output step. The unit returns to idle before the
//    next beat is accepted.
//  - If rsp_stall holds the previous result, the finished pose waits in
//    the sequencer and req_stall stays high.
//  - Reset: registers take their reset values, pose = start pose (origin).
module ackermann_pose_update_unit import apu_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_cmd,
   input  logic signed [23:0] req_speed,
   input  logic signed [15:0] req_steer_or_rate,
   input  logic [15:0]        req_time_step,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic [15:0]        rsp_heading,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_ATAN_MUL, ST_ATAN_LOAD, ST_ATAN_RUN, ST_ROT1_LOAD, ST_ROT1_RUN,
      ST_ROT2_LOAD, ST_ROT2_RUN, ST_MX1, ST_MX2, ST_MY1, ST_MY2, ST_MH1, ST_MH2,
      ST_MH3, ST_DIV_LOAD, ST_DIV_RUN, ST_HEAD, ST_DONE
   } state_type;

   state_type state_ff;

   // configuration
   logic [23:0]        wheelbase_ff;
   logic               steer_is_angle_ff;
   logic signed [31:0] start_x_ff, start_y_ff;
   logic [15:0]        start_heading_ff;

   // pose and item registers
   logic signed [31:0] cur_x_ff, cur_y_ff;
   logic [15:0]        cur_heading_ff;
   logic signed [23:0] v_ff;
   logic signed [15:0] st_ff;
   logic [15:0]        dt_ff;
   logic [31:0]        delta_ff;
   logic signed [31:0] c1_ff, s1_ff, s2_ff;
   logic signed [63:0] prod_ff;
   logic               neg_ff, qneg_ff;
   logic               rsp_valid_ff;
   logic signed [31:0] out_x_ff, out_y_ff;
   logic [15:0]        out_heading_ff;

   logic [23:0] len;
   assign len = (wheelbase_ff == 24'd0) ? 24'd1 : wheelbase_ff;

   // shared multiplier, operands chosen by state, product registered
   logic signed [41:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [73:0] mul_full;
   logic signed [63:0] p_sh14, p_sh16;
   assign p_sh14 = prod_ff >>> 14;
   assign p_sh16 = prod_ff >>> 16;

   always_comb begin
      mul_a = 42'(v_ff);
      mul_b = c1_ff;
      unique case (state_ff)
         ST_ATAN_MUL: begin
            mul_a = $signed({18'd0, len});
            mul_b = 32'(st_ff);
         end
         ST_MX2, ST_MY2, ST_MH2: begin
            mul_a = p_sh14[41:0];
            mul_b = $signed({16'd0, dt_ff});
         end
         ST_MY1: mul_b = s1_ff;
         ST_MH1: mul_b = s2_ff;
         ST_MH3: begin
            mul_a = p_sh16[41:0];
            mul_b = TURN_OVER_2PI_Q8;
         end
         default: ;
      endcase
      mul_full = mul_a * mul_b;
   end

   // position step: round(p*dt / 2^32), saturated add
   logic signed [63:0] rnd_sum;
   logic signed [33:0] pos_sum;
   logic signed [31:0] cur_sel, pos_sat;
   always_comb begin
      rnd_sum = prod_ff + 64'sd2147483648;
      cur_sel = (state_ff == ST_MY1) ? cur_x_ff : cur_y_ff;
      pos_sum = 34'(cur_sel) + 34'($signed(rnd_sum[63:32]));
      if (pos_sum > 34'sd2147483647)       pos_sat = 32'sh7FFFFFFF;
      else if (pos_sum < -34'sd2147483648) pos_sat = 32'sh80000000;
      else                                 pos_sat = pos_sum[31:0];
   end

   // CORDIC load: arctangent operands or folded rotation angle
   cor_ctl_type            cor_ctl;
   logic signed [XY_W-1:0] cx0, cy0, cx, cy;
   logic signed [Z_W-1:0]  cz0, cz;
   logic                   cor_done;
   logic [31:0]            rot_ang, rot_fold, rot_sum;
   logic                   rot_neg;
   logic signed [XY_W-1:0] vx, vy;

   always_comb begin
      rot_ang  = (state_ff == ST_ROT1_LOAD) ? ({cur_heading_ff, 16'd0} + delta_ff) : delta_ff;
      rot_sum  = rot_ang + 32'h40000000;
      rot_neg  = rot_sum[31];
      rot_fold = rot_neg ? (rot_ang + 32'h80000000) : rot_ang;
      vx = XY_W'(v_ff) <<< 12;
      vy = XY_W'($signed(prod_ff[40:0]));
      cor_ctl.start     = (state_ff == ST_ATAN_LOAD && v_ff != 24'sd0)
                       || state_ff == ST_ROT1_LOAD || state_ff == ST_ROT2_LOAD;
      cor_ctl.vectoring = (state_ff == ST_ATAN_LOAD);
      if (state_ff == ST_ATAN_LOAD) begin
         cx0 = v_ff[23] ? -vx : vx;
         cy0 = v_ff[23] ? -vy : vy;
         cz0 = '0;
      end else begin
         cx0 = CORDIC_GAIN;
         cy0 = '0;
         cz0 = Z_W'($signed(rot_fold));
      end
   end

   apu_cordic u_cordic (
      .clock(clock), .reset(reset), .ctl(cor_ctl),
      .x_init(cx0), .y_init(cy0), .z_init(cz0),
      .x_out(cx), .y_out(cy), .z_out(cz), .done(cor_done)
   );

   logic signed [XY_W-1:0] cx_fix, cy_fix;
   assign cx_fix = neg_ff ? -cx : cx;
   assign cy_fix = neg_ff ? -cy : cy;

   // heading divide: |P| / L, sign restored afterward
   logic        div_start, div_done;
   logic [63:0] div_dvd, div_q;
   logic signed [63:0] q_signed, q_rnd;
   assign div_start = (state_ff == ST_DIV_LOAD);
   assign div_dvd   = prod_ff[63] ? 64'(-prod_ff) : 64'(prod_ff);
   assign q_signed  = qneg_ff ? -$signed(div_q) : $signed(div_q);
   assign q_rnd     = q_signed + 64'sd8388608;

   apu_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_dvd),
      .divisor(len), .quotient(div_q), .done(div_done)
   );

   logic req_acc, rsp_free;
   assign req_acc  = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         rsp_valid_ff      <= 1'b0;
         wheelbase_ff      <= 24'd256;
         steer_is_angle_ff <= 1'b0;
         start_x_ff        <= '0;
         start_y_ff        <= '0;
         start_heading_ff  <= '0;
         cur_x_ff          <= '0;
         cur_y_ff          <= '0;
         cur_heading_ff    <= '0;
      end else begin
         if (csr_we) begin
            case (csr_idx_type'(csr_index))
               CSR_WHEELBASE:      wheelbase_ff <= csr_wdata[23:0];
               CSR_STEER_IS_ANGLE: steer_is_angle_ff <= csr_wdata[0];
               CSR_START_X:        start_x_ff <= csr_wdata;
               CSR_START_Y:        start_y_ff <= csr_wdata;
               CSR_START_HEADING:  start_heading_ff <= csr_wdata[15:0];
               default: ;
            endcase
         end
         // the output step below reloads the register itself
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_DONE) rsp_valid_ff <= 1'b0;
         prod_ff <= mul_full[63:0];
         unique case (state_ff)
            ST_IDLE: if (req_acc) begin
               v_ff <= req_speed; st_ff <= req_steer_or_rate; dt_ff <= req_time_step;
               delta_ff <= {req_steer_or_rate, 16'd0};
               if (req_cmd) begin
                  cur_x_ff <= start_x_ff; cur_y_ff <= start_y_ff;
                  cur_heading_ff <= start_heading_ff;
                  state_ff <= ST_DONE;
               end else if (steer_is_angle_ff) state_ff <= ST_ROT1_LOAD;
               else state_ff <= ST_ATAN_MUL;
            end
            ST_ATAN_MUL: state_ff <= ST_ATAN_LOAD;
            ST_ATAN_LOAD: begin
               // zero speed: angle is zero, no arctangent pass
               delta_ff <= '0;
               state_ff <= (v_ff == 24'sd0) ? ST_ROT1_LOAD : ST_ATAN_RUN;
            end
            ST_ATAN_RUN: if (cor_done) begin
               delta_ff <= cz[31:0];
               state_ff <= ST_ROT1_LOAD;
            end
            ST_ROT1_LOAD: begin
               neg_ff <= rot_neg;
               state_ff <= ST_ROT1_RUN;
            end
            ST_ROT1_RUN: if (cor_done) begin
               c1_ff <= cx_fix[31:0]; s1_ff <= cy_fix[31:0];
               state_ff <= ST_ROT2_LOAD;
            end
            ST_ROT2_LOAD: begin
               neg_ff <= rot_neg;
               state_ff <= ST_ROT2_RUN;
            end
            ST_ROT2_RUN: if (cor_done) begin
               s2_ff <= cy_fix[31:0];
               state_ff <= ST_MX1;
            end
            ST_MX1: state_ff <= ST_MX2;
            ST_MX2: state_ff <= ST_MY1;
            ST_MY1: begin
               cur_x_ff <= pos_sat;
               state_ff <= ST_MY2;
            end
            ST_MY2: state_ff <= ST_MH1;
            ST_MH1: begin
               cur_y_ff <= pos_sat;
               state_ff <= ST_MH2;
            end
            ST_MH2: state_ff <= ST_MH3;
            ST_MH3: state_ff <= ST_DIV_LOAD;
            ST_DIV_LOAD: begin
               qneg_ff <= prod_ff[63];
               state_ff <= ST_DIV_RUN;
            end
            ST_DIV_RUN: if (div_done) state_ff <= ST_HEAD;
            ST_HEAD: begin
               cur_heading_ff <= cur_heading_ff + q_rnd[39:24];
               state_ff <= ST_DONE;
            end
            ST_DONE: if (rsp_free) begin
               out_x_ff <= cur_x_ff; out_y_ff <= cur_y_ff;
               out_heading_ff <= cur_heading_ff;
               rsp_valid_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pos_x   = out_x_ff;
   assign rsp_pos_y   = out_y_ff;
   assign rsp_heading = out_heading_ff;

   // an accepted beat closes the input until its result is out
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted while busy");

   a_cordic_done_state: assert property (@(posedge clock) disable iff (reset)
      cor_done |-> (state_ff == ST_ATAN_RUN || state_ff == ST_ROT1_RUN
                    || state_ff == ST_ROT2_RUN))
      else $error("CORDIC finished outside a run state");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV_RUN)
      else $error("divider finished outside its run state");

   a_result_load: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && rsp_free |=> rsp_valid && state_ff == ST_IDLE)
      else $error("finished pose not presented");

endmodule

/* dv/apu_pose_checker.sv */
// Pose update checker: watches the request, response and register ports, predicts and compares.
`timescale 1ns / 100ps
module apu_pose_checker import apu_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_cmd,
   input  logic signed [23:0] req_speed,
   input  logic signed [15:0] req_steer_or_rate,
   input  logic [15:0]        req_time_step,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [31:0] rsp_pos_x,
   input  logic signed [31:0] rsp_pos_y,
   input  logic [15:0]        rsp_heading,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   output int                 fail_count,
   output int                 pending
);

   localparam longint GAIN_Q30 = 652032874;
   localparam longint TURN_Q8 = 2670177;

   localparam logic [31:0] ARCTAN [24] = '{
      32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
      32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051};

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic [15:0]        hdg;
   } pose_type;

   logic [23:0]        wheelbase;
   logic               steer_is_angle;
   logic signed [31:0] start_x, start_y;
   logic [15:0]        start_hdg;
   pose_type           pose;
   pose_type           pose_q[$];

   assign pending = pose_q.size();

   function automatic longint round_shift(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // rotation CORDIC, Q1.30 cos/sin of a 32-bit binary angle
   function automatic void rotate(input logic [31:0] ang, output longint c, output longint s);
      logic [31:0] a;
      bit          flip;
      longint      x, y, z, nx;
      a = ang;
      flip = 0;
      x = GAIN_Q30;
      y = 0;
      if (((a + 32'h40000000) & 32'h80000000) != 0) begin
         a = a + 32'h80000000;
         flip = 1;
      end
      z = longint'($signed(a));
      for (int i = 0; i < NSTEPS; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= longint'(ARCTAN[i]);
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += longint'(ARCTAN[i]);
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   // vectoring CORDIC, angle of (x, y) as 32-bit binary angle
   function automatic logic [31:0] vector_angle(longint y, longint x);
      longint z, nx;
      z = 0;
      if (x == 0) return 32'h0;
      if (x < 0) begin
         x = -x;
         y = -y;
      end
      for (int i = 0; i < NSTEPS; i++) begin
         if (y >= 0) begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += longint'(ARCTAN[i]);
         end else begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= longint'(ARCTAN[i]);
         end
         x = nx;
      end
      return z[31:0];
   endfunction

   function automatic pose_type advance_pose(pose_type p0, longint v, longint st, longint dt);
      pose_type    p1;
      longint      len, c, s, m, n, q;
      logic [31:0] delta;
      len = (wheelbase == 0) ? 1 : longint'(wheelbase);
      if (steer_is_angle) delta = {st[15:0], 16'h0};
      else delta = vector_angle(len * st, v * 4096);
      rotate({p0.hdg, 16'h0} + delta, c, s);
      m = (v * c) >>> 14;
      p1.x = clamp32(longint'(p0.x) + round_shift(m * dt, 32));
      m = (v * s) >>> 14;
      p1.y = clamp32(longint'(p0.y) + round_shift(m * dt, 32));
      rotate(delta, c, s);
      n = (((v * s) >>> 14) * dt) >>> 16;
      q = (n * TURN_Q8) / len;
      p1.hdg = p0.hdg + 16'(round_shift(q, 24));
      return p1;
   endfunction

   always @(posedge clock) begin
      pose_type got, want;
      int       errs;
      errs = 0;
      if (reset) begin
         wheelbase <= 24'd256;
         steer_is_angle <= 1'b0;
         start_x <= '0;
         start_y <= '0;
         start_hdg <= '0;
         pose <= '{0, 0, 0};
         pose_q.delete();
         fail_count <= 0;
      end else begin
         if (csr_we) begin
            case (csr_idx_type'(csr_index))
               CSR_WHEELBASE:      wheelbase <= csr_wdata[23:0];
               CSR_STEER_IS_ANGLE: steer_is_angle <= csr_wdata[0];
               CSR_START_X:        start_x <= csr_wdata;
               CSR_START_Y:        start_y <= csr_wdata;
               CSR_START_HEADING:  start_hdg <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (req_cmd) want = '{start_x, start_y, start_hdg};
            else want = advance_pose(pose, longint'(req_speed), longint'(req_steer_or_rate),
                                     longint'(req_time_step));
            pose <= want;
            pose_q.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_pos_x, rsp_pos_y, rsp_heading};
            if (pose_q.size() == 0) begin
               $error("response beat with no pose expected");
               errs++;
            end else begin
               want = pose_q.pop_front();
               if (got.x !== want.x) begin
                  $error("pos_x expected %0d actual %0d", want.x, got.x);
                  errs++;
               end
               if (got.y !== want.y) begin
                  $error("pos_y expected %0d actual %0d", want.y, got.y);
                  errs++;
               end
               if (got.hdg !== want.hdg) begin
                  $error("heading expected %0d actual %0d", want.hdg, got.hdg);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
   end

endmodule

/* dv/tb_ackermann_pose_update_unit.sv */
// Testbench top for the pose update unit: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_ackermann_pose_update_unit;
   import apu_pkg::*;

   localparam logic CMD_ADVANCE = 1'b0;
   localparam logic CMD_RESTART = 1'b1;
   // settle with margin beyond the advance sequence
   localparam int SETTLE = 3 * NSTEPS + 200;
   localparam int CYCLE_LIMIT = 2000000;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   logic               req_cmd = 0;
   logic signed [23:0] req_speed = 0;
   logic signed [15:0] req_steer_or_rate = 0;
   logic [15:0]        req_time_step = 0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic signed [31:0] rsp_pos_x, rsp_pos_y;
   logic [15:0]        rsp_heading;
   logic               csr_we = 0;
   logic [2:0]         csr_index = 0;
   logic [31:0]        csr_wdata = 0;

   int  fail_count, pending;
   int  cycles = 0;
   bit  no_idle = 0;      // phases with back-to-back beats on both sides
   bit  long_hold = 0;    // receiver parks for a long stretch once

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   ackermann_pose_update_unit uut (.*);

   apu_pose_checker chk (.*);

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // response side: random stall before each beat, one long hold-off on request
   initial begin
      int n;
      @(negedge reset);
      forever begin
         n = no_idle ? 0 : $urandom_range(0, 19);
         if (long_hold) begin
            n = 800;
            long_hold = 0;
         end
         if (n > 0) begin
            rsp_stall <= 1;
            repeat (n) @(posedge clock);
            rsp_stall <= 0;
         end
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic reg_write(csr_idx_type idx, logic [31:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
   endtask

   // wait for every pose to come back and the unit to go quiet
   task automatic drain();
      req_valid <= 0;
      wait (pending == 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // one request beat; valid stays high across back-to-back beats
   task automatic send_beat(logic cmd, logic [23:0] spd, logic [15:0] st, logic [15:0] dt);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_cmd <= cmd;
      req_speed <= spd;
      req_steer_or_rate <= st;
      req_time_step <= dt;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic random_beat();
      logic [23:0] spd;
      if ($urandom_range(0, 19) == 0) begin
         send_beat(CMD_RESTART, 24'($urandom), 16'($urandom), 16'($urandom));
      end else begin
         case ($urandom_range(0, 3))
            0: spd = 24'($urandom);
            1: spd = 24'($signed($urandom_range(0, 4095)) - 2048);
            2: spd = 0;
            default: spd = 24'($signed($urandom_range(0, 131071)) - 65536);
         endcase
         send_beat(CMD_ADVANCE, spd, 16'($urandom), 16'($urandom));
      end
   endtask

   task automatic configure(logic [23:0] wb, logic angle_mode, logic [31:0] sx,
                            logic [31:0] sy, logic [15:0] sh);
      drain();
      reg_write(CSR_WHEELBASE, {8'h0, wb});
      reg_write(CSR_STEER_IS_ANGLE, {31'h0, angle_mode});
      reg_write(CSR_START_X, sx);
      reg_write(CSR_START_Y, sy);
      reg_write(CSR_START_HEADING, {16'h0, sh});
   endtask

   initial begin
      logic [23:0] wb_pick [5];
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed, reset config (yaw-rate mode, wheelbase 256, origin)
      send_beat(CMD_ADVANCE, 24'h7FFFFF, 16'h7FFF, 16'hFFFF);
      send_beat(CMD_ADVANCE, 24'h800000, 16'h8000, 16'hFFFF);
      send_beat(CMD_ADVANCE, 24'h0, 16'h1234, 16'hFFFF);      // zero speed, yaw mode
      send_beat(CMD_ADVANCE, 24'h000100, 16'h0, 16'h0);       // zero time step
      send_beat(CMD_ADVANCE, 24'hFFFF00, 16'hF000, 16'h8000);
      send_beat(CMD_RESTART, 24'h0, 16'h0, 16'h0);

      // angle mode, zero wheelbase treated as one, start pose near the limits
      configure(24'h0, 1'b1, 32'h7FFFFF00, 32'h80000100, 16'hFFFF);
      send_beat(CMD_ADVANCE, 24'h7FFFFF, 16'h0, 16'hFFFF);    // advances from the origin, start pose not loaded yet
      send_beat(CMD_RESTART, 24'h0, 16'h0, 16'h0);
      send_beat(CMD_ADVANCE, 24'h7FFFFF, 16'hC000, 16'hFFFF); // y saturates low
      send_beat(CMD_ADVANCE, 24'h800000, 16'h4000, 16'hFFFF);
      send_beat(CMD_ADVANCE, 24'h000400, 16'h7FFF, 16'h1000);
      send_beat(CMD_ADVANCE, 24'h000400, 16'h8000, 16'h1000);
      // start registers written later only take effect at the next restart
      configure(24'hFFFFFF, 1'b1, 32'h80000000, 32'h7FFFFFFF, 16'h8000);
      send_beat(CMD_ADVANCE, 24'h000100, 16'h2000, 16'h0100);
      send_beat(CMD_RESTART, 24'h0, 16'h0, 16'h0);
      send_beat(CMD_ADVANCE, 24'h800000, 16'h2000, 16'hFFFF);
      configure(24'h1, 1'b0, 32'h0, 32'h0, 16'h0);
      send_beat(CMD_RESTART, 24'h0, 16'h0, 16'h0);
      send_beat(CMD_ADVANCE, 24'h7FFFFF, 16'h7FFF, 16'hFFFF);
      send_beat(CMD_ADVANCE, 24'h800000, 16'h8000, 16'h4000);

      // pressure: receiver parks while the sender keeps offering
      drain();
      long_hold = 1;
      repeat (8) random_beat();

      // random phases over a spread of settings
      wb_pick = '{24'd256, 24'd1, 24'hFFFFFF, 24'd0, 24'd0};
      for (int ph = 0; ph < 8; ph++) begin
         wb_pick[4] = 24'($urandom);
         configure(wb_pick[$urandom_range(0, 4)], ph[0], $urandom, $urandom, 16'($urandom));
         no_idle = (ph % 4 == 3);
         send_beat(CMD_RESTART, 24'h0, 16'h0, 16'h0);
         repeat (140) random_beat();
      end
      no_idle = 0;
      req_valid <= 0;

      wait (pending == 0);
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
